[hw/rtl/vpcr_pkg.sv]
// Shared constants, types and CORDIC helper functions for the polar convert / rotate unit.
package vpcr_pkg;

	// Field widths
	localparam int DATA_WIDTH  = 16;
	localparam int ANGLE_WIDTH = 16;

	// CORDIC schedule: two micro-rotations per pipeline stage
	localparam int ITERATIONS     = 16;
	localparam int ITER_PER_STAGE = 2;
	localparam int ITER_STAGES    = ITERATIONS / ITER_PER_STAGE;
	localparam int IW             = 5;

	// Internal precision
	localparam int GUARD     = 16;
	localparam int ZW        = 32;
	localparam int PW        = DATA_WIDTH + 2;
	localparam int CW        = PW + GUARD + 2;
	localparam int GAIN_FRAC = 32;
	localparam int GAIN_W    = GAIN_FRAC + 2;
	localparam int PRD_W     = PW + GAIN_W;
	localparam int PS_SHIFT  = GAIN_FRAC - GUARD;

	// 1/K scaled by 2^32
	localparam logic signed [GAIN_W-1:0] INV_GAIN = 34'sd2608131496;

	// Operation codes
	localparam logic [1:0] OP_TO_POLAR = 2'd0;
	localparam logic [1:0] OP_ROT_CCW  = 2'd1;
	localparam logic [1:0] OP_ROT_CW   = 2'd2;
	localparam logic [1:0] OP_TO_XY    = 2'd3;

	// Internal angle: full turn is 2^ZW
	localparam logic [ZW-1:0] HALF_TURN    = ZW'(1) << (ZW - 1);
	localparam logic [ZW-1:0] QUARTER_TURN = ZW'(1) << (ZW - 2);
	localparam logic [ZW-1:0] ANG_ROUND    = ZW'(1) << (ZW - ANGLE_WIDTH - 1);

	// Exact axis angles in output counts
	localparam logic [ANGLE_WIDTH-1:0] ANG_ZERO  = '0;
	localparam logic [ANGLE_WIDTH-1:0] ANG_POS_Y = ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 2);
	localparam logic [ANGLE_WIDTH-1:0] ANG_NEG_X = ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 1);
	localparam logic [ANGLE_WIDTH-1:0] ANG_NEG_Y = ANGLE_WIDTH'(3) << (ANGLE_WIDTH - 2);

	// Coordinate clip limits
	localparam logic signed [PW-1:0] XMAX = PW'((2 ** (DATA_WIDTH - 1)) - 1);
	localparam logic signed [PW-1:0] XMIN = -XMAX - PW'(1);

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [PW-1:0] pval_t;

	// CORDIC working vector
	typedef struct packed {
		coord_t          x;
		coord_t          y;
		logic [ZW-1:0]   z;
	} cstate_t;

	// Fields that ride along with each request
	typedef struct packed {
		logic [1:0]                    op;
		logic signed [DATA_WIDTH-1:0]  x;
		logic signed [DATA_WIDTH-1:0]  y;
		logic [DATA_WIDTH-2:0]         lin;
		logic [ANGLE_WIDTH-1:0]        ang;
		logic signed [DATA_WIDTH-1:0]  xo;
		logic signed [DATA_WIDTH-1:0]  yo;
		logic                          sat;
		logic                          spec;
		logic [DATA_WIDTH-1:0]         spec_len;
		logic [ANGLE_WIDTH-1:0]        spec_ang;
	} side_t;

	// atan(2^-i), full turn = 2^32
	function automatic logic [ZW-1:0] atan_val(input logic [IW-1:0] i);
		logic [ZW-1:0] a;
		case (i)
			5'd0:    a = 32'h20000000;
			5'd1:    a = 32'h12E4051E;
			5'd2:    a = 32'h09FB385B;
			5'd3:    a = 32'h051111D4;
			5'd4:    a = 32'h028B0D43;
			5'd5:    a = 32'h0145D7E1;
			5'd6:    a = 32'h00A2F61E;
			5'd7:    a = 32'h00517C55;
			5'd8:    a = 32'h0028BE53;
			5'd9:    a = 32'h00145F2F;
			5'd10:   a = 32'h000A2F98;
			5'd11:   a = 32'h000517CC;
			5'd12:   a = 32'h00028BE6;
			5'd13:   a = 32'h000145F3;
			5'd14:   a = 32'h0000A2FA;
			5'd15:   a = 32'h0000517D;
			5'd16:   a = 32'h000028BE;
			5'd17:   a = 32'h0000145F;
			5'd18:   a = 32'h00000A30;
			5'd19:   a = 32'h00000518;
			5'd20:   a = 32'h0000028C;
			5'd21:   a = 32'h00000146;
			5'd22:   a = 32'h000000A3;
			5'd23:   a = 32'h00000051;
			5'd24:   a = 32'h00000029;
			5'd25:   a = 32'h00000014;
			5'd26:   a = 32'h0000000A;
			5'd27:   a = 32'h00000005;
			5'd28:   a = 32'h00000003;
			5'd29:   a = 32'h00000001;
			5'd30:   a = 32'h00000001;
			default: a = 32'h00000000;
		endcase
		return a;
	endfunction

	// One micro-rotation; vec selects vectoring (drive y to zero) or rotation (drive z to zero)
	function automatic cstate_t cordic_iter(input cstate_t s, input logic [IW-1:0] idx,
			input logic vec);
		cstate_t        r;
		coord_t         dx;
		coord_t         dy;
		logic [ZW-1:0]  a;
		logic           ccw;
		dx  = $signed(s.y) >>> idx;
		dy  = $signed(s.x) >>> idx;
		a   = atan_val(idx);
		ccw = vec ? s.y[CW-1] : ~s.z[ZW-1];
		if (ccw) begin
			r.x = s.x - dx;
			r.y = s.y + dy;
			r.z = s.z - a;
		end else begin
			r.x = s.x + dx;
			r.y = s.y - dy;
			r.z = s.z + a;
		end
		return r;
	endfunction

	// Micro-rotations handled by one pipeline stage
	function automatic cstate_t stage_iter(input cstate_t s, input logic [IW-1:0] first,
			input logic vec);
		cstate_t r;
		r = s;
		for (int j = 0; j < ITER_PER_STAGE; j++) begin
			r = cordic_iter(r, first + IW'(j), vec);
		end
		return r;
	endfunction

	// Gain compensation: v * 1/K, rounded to GUARD fraction bits
	function automatic coord_t prescale(input pval_t v);
		logic signed [PRD_W-1:0] vx;
		logic signed [PRD_W-1:0] gx;
		logic signed [PRD_W-1:0] p;
		vx = PRD_W'(v);
		gx = PRD_W'(INV_GAIN);
		p  = vx * gx + (PRD_W'(1) << (PS_SHIFT - 1));
		return CW'(p >>> PS_SHIFT);
	endfunction

	// Drop guard bits, round half up
	function automatic pval_t round_out(input coord_t v);
		coord_t t;
		t = v + (CW'(1) << (GUARD - 1));
		return PW'(t >>> GUARD);
	endfunction

	// Length clamp to [0, 2^DATA_WIDTH - 1]
	function automatic logic [DATA_WIDTH-1:0] len_clip(input pval_t v);
		logic [DATA_WIDTH-1:0] r;
		if (v[PW-1]) begin
			r = '0;
		end else if (|v[PW-2:DATA_WIDTH]) begin
			r = '1;
		end else begin
			r = v[DATA_WIDTH-1:0];
		end
		return r;
	endfunction

endpackage

[hw/rtl/vector_polar_convert_rotate_top.sv]
// Top level of the pipelined CORDIC polar convert / rotate unit.
// Throughput: one request per clock unless a held output stalls the pipe.
// Register chain: input fold, rotation prescale multiply, 8 rotation
// stages, rotation round/clip, vectoring prescale multiply, 8 vectoring stages, output.
// A held output stalls every stage together; nothing is dropped or repeated.
// arst_n clears all stage valid bits asynchronously; data registers are not reset.
module vector_polar_convert_rotate_top (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      in_valid,
	output logic                                      in_stall,
	input  logic [1:0]                                op,
	input  logic signed [vpcr_pkg::DATA_WIDTH-1:0]    x_in,
	input  logic signed [vpcr_pkg::DATA_WIDTH-1:0]    y_in,
	input  logic [vpcr_pkg::DATA_WIDTH-2:0]           length_in,
	input  logic signed [vpcr_pkg::ANGLE_WIDTH-1:0]   angle_in,
	output logic                                      out_valid,
	input  logic                                      out_stall,
	output logic signed [vpcr_pkg::DATA_WIDTH-1:0]    x_out,
	output logic signed [vpcr_pkg::DATA_WIDTH-1:0]    y_out,
	output logic [vpcr_pkg::DATA_WIDTH-1:0]           length_out,
	output logic signed [vpcr_pkg::ANGLE_WIDTH-1:0]   angle_out,
	output logic                                      saturated
);

	localparam int NS = vpcr_pkg::ITER_STAGES;
	localparam int DW = vpcr_pkg::DATA_WIDTH;
	localparam int AW = vpcr_pkg::ANGLE_WIDTH;
	localparam int ZW = vpcr_pkg::ZW;
	localparam int PW = vpcr_pkg::PW;

	logic adv;

	// stage 1: quadrant fold for rotation
	logic [ZW-1:0]     theta;
	logic [ZW-1:0]     theta_q;
	vpcr_pkg::pval_t   fx;
	vpcr_pkg::pval_t   fy;
	logic [ZW-1:0]     fz;
	vpcr_pkg::side_t   side_in;

	logic              v_s1;
	vpcr_pkg::pval_t   rx_s1;
	vpcr_pkg::pval_t   ry_s1;
	logic [ZW-1:0]     rz_s1;
	vpcr_pkg::side_t   side_s1;

	// rotation chain: index 0 is the prescale register
	logic [NS:0]       rot_v_s;
	vpcr_pkg::cstate_t rot_s      [0:NS];
	vpcr_pkg::side_t   rot_side_s [0:NS];

	// stage 3: rotation result, clip, vectoring setup
	vpcr_pkg::side_t   rs;
	vpcr_pkg::side_t   side3;
	vpcr_pkg::pval_t   xr;
	vpcr_pkg::pval_t   yr;
	vpcr_pkg::pval_t   px;
	vpcr_pkg::pval_t   py;
	vpcr_pkg::pval_t   ax;
	vpcr_pkg::pval_t   ay;
	vpcr_pkg::pval_t   vx;
	vpcr_pkg::pval_t   vy;
	logic [ZW-1:0]     vz;

	logic              v_s3;
	vpcr_pkg::pval_t   vx_s3;
	vpcr_pkg::pval_t   vy_s3;
	logic [ZW-1:0]     vz_s3;
	vpcr_pkg::side_t   side_s3;

	// vectoring chain: index 0 is the prescale register
	logic [NS:0]       vec_v_s;
	vpcr_pkg::cstate_t vec_s      [0:NS];
	vpcr_pkg::side_t   vec_side_s [0:NS];

	// output stage
	vpcr_pkg::side_t   fs;
	vpcr_pkg::pval_t   lr;
	logic [ZW-1:0]     zr;
	logic [DW-1:0]     len_nx;
	logic [AW-1:0]     ang_nx;

	logic              v_s5;
	logic signed [DW-1:0] x_s5;
	logic signed [DW-1:0] y_s5;
	logic [DW-1:0]     len_s5;
	logic [AW-1:0]     ang_s5;
	logic              sat_s5;

	// whole pipe moves unless a finished result is held
	assign adv      = !(v_s5 && out_stall);
	assign in_stall = !adv;

	// input fold: bring rotation angle into [-quarter, quarter)
	always_comb begin
		theta = {angle_in, {(ZW - AW){1'b0}}};
		if (op == vpcr_pkg::OP_TO_XY) begin
			fx = PW'(length_in);
			fy = '0;
		end else begin
			fx = PW'(x_in);
			fy = PW'(y_in);
		end
		if (op == vpcr_pkg::OP_ROT_CW) begin
			theta = -theta;
		end
		theta_q = theta + vpcr_pkg::QUARTER_TURN;
		fz      = theta;
		if (theta_q[ZW-1]) begin
			fx = -fx;
			fy = -fy;
			fz = theta ^ vpcr_pkg::HALF_TURN;
		end
		side_in          = '0;
		side_in.op       = op;
		side_in.x        = x_in;
		side_in.y        = y_in;
		side_in.lin      = length_in;
		side_in.ang      = angle_in;
	end

	// rotation result: round, clip, pick vectoring input, axis cases
	always_comb begin
		rs    = rot_side_s[NS];
		side3 = rs;
		xr    = vpcr_pkg::round_out(rot_s[NS].x);
		yr    = vpcr_pkg::round_out(rot_s[NS].y);
		if (rs.op == vpcr_pkg::OP_TO_POLAR) begin
			side3.xo  = rs.x;
			side3.yo  = rs.y;
			side3.sat = 1'b0;
			px        = PW'($signed(rs.x));
			py        = PW'($signed(rs.y));
		end else begin
			side3.xo  = (xr > vpcr_pkg::XMAX) ? DW'(vpcr_pkg::XMAX) :
					(xr < vpcr_pkg::XMIN) ? DW'(vpcr_pkg::XMIN) : DW'(xr);
			side3.yo  = (yr > vpcr_pkg::XMAX) ? DW'(vpcr_pkg::XMAX) :
					(yr < vpcr_pkg::XMIN) ? DW'(vpcr_pkg::XMIN) : DW'(yr);
			side3.sat = (xr > vpcr_pkg::XMAX) || (xr < vpcr_pkg::XMIN) ||
					(yr > vpcr_pkg::XMAX) || (yr < vpcr_pkg::XMIN);
			px        = xr;
			py        = yr;
		end
		ax = px[PW-1] ? -px : px;
		ay = py[PW-1] ? -py : py;
		// zero vector and vectors on an axis are exact
		side3.spec     = 1'b1;
		side3.spec_len = '0;
		side3.spec_ang = vpcr_pkg::ANG_ZERO;
		if (px == '0 && py == '0) begin
			side3.spec_len = '0;
		end else if (py == '0) begin
			side3.spec_len = vpcr_pkg::len_clip(ax);
			side3.spec_ang = px[PW-1] ? vpcr_pkg::ANG_NEG_X : vpcr_pkg::ANG_ZERO;
		end else if (px == '0) begin
			side3.spec_len = vpcr_pkg::len_clip(ay);
			side3.spec_ang = py[PW-1] ? vpcr_pkg::ANG_NEG_Y : vpcr_pkg::ANG_POS_Y;
		end else begin
			side3.spec = 1'b0;
		end
		// left half plane: turn by a half turn first
		vx = px;
		vy = py;
		vz = '0;
		if (px[PW-1]) begin
			vx = -px;
			vy = -py;
			vz = vpcr_pkg::HALF_TURN;
		end
	end

	// final length and angle selection
	always_comb begin
		fs = vec_side_s[NS];
		lr = vpcr_pkg::round_out(vec_s[NS].x);
		zr = vec_s[NS].z + vpcr_pkg::ANG_ROUND;
		if (fs.op == vpcr_pkg::OP_TO_XY) begin
			len_nx = DW'(fs.lin);
			ang_nx = fs.ang;
		end else if (fs.spec) begin
			len_nx = fs.spec_len;
			ang_nx = fs.spec_ang;
		end else begin
			len_nx = vpcr_pkg::len_clip(lr);
			ang_nx = zr[ZW-1 -: AW];
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			rot_v_s <= '0;
			v_s3    <= 1'b0;
			vec_v_s <= '0;
			v_s5    <= 1'b0;
		end else if (adv) begin
			v_s1    <= in_valid;
			rot_v_s <= {rot_v_s[NS-1:0], v_s1};
			v_s3    <= rot_v_s[NS];
			vec_v_s <= {vec_v_s[NS-1:0], v_s3};
			v_s5    <= vec_v_s[NS];
		end
	end

	// stage data
	always_ff @(posedge clk) begin
		if (adv) begin
			rx_s1   <= fx;
			ry_s1   <= fy;
			rz_s1   <= fz;
			side_s1 <= side_in;

			rot_s[0].x    <= vpcr_pkg::prescale(rx_s1);
			rot_s[0].y    <= vpcr_pkg::prescale(ry_s1);
			rot_s[0].z    <= rz_s1;
			rot_side_s[0] <= side_s1;
			for (int k = 0; k < NS; k++) begin
				rot_s[k+1]      <= vpcr_pkg::stage_iter(rot_s[k],
						vpcr_pkg::IW'(k * vpcr_pkg::ITER_PER_STAGE), 1'b0);
				rot_side_s[k+1] <= rot_side_s[k];
			end

			vx_s3   <= vx;
			vy_s3   <= vy;
			vz_s3   <= vz;
			side_s3 <= side3;

			vec_s[0].x    <= vpcr_pkg::prescale(vx_s3);
			vec_s[0].y    <= vpcr_pkg::prescale(vy_s3);
			vec_s[0].z    <= vz_s3;
			vec_side_s[0] <= side_s3;
			for (int k = 0; k < NS; k++) begin
				vec_s[k+1]      <= vpcr_pkg::stage_iter(vec_s[k],
						vpcr_pkg::IW'(k * vpcr_pkg::ITER_PER_STAGE), 1'b1);
				vec_side_s[k+1] <= vec_side_s[k];
			end

			x_s5   <= fs.xo;
			y_s5   <= fs.yo;
			sat_s5 <= fs.sat;
			len_s5 <= len_nx;
			ang_s5 <= ang_nx;
		end
	end

	assign out_valid  = v_s5;
	assign x_out      = x_s5;
	assign y_out      = y_s5;
	assign length_out = len_s5;
	assign angle_out  = ang_s5;
	assign saturated  = sat_s5;

endmodule

[hw/rtl/vpcr_chk.sv]
// Port-level checker for the polar convert / rotate unit, with its bind.
module vpcr_chk (
	input logic                                     clk,
	input logic                                     arst_n,
	input logic                                     in_stall,
	input logic                                     out_valid,
	input logic                                     out_stall,
	input logic signed [vpcr_pkg::DATA_WIDTH-1:0]   x_out,
	input logic signed [vpcr_pkg::DATA_WIDTH-1:0]   y_out,
	input logic [vpcr_pkg::DATA_WIDTH-1:0]          length_out,
	input logic signed [vpcr_pkg::ANGLE_WIDTH-1:0]  angle_out,
	input logic                                     saturated
);

	localparam int DW = vpcr_pkg::DATA_WIDTH;
	localparam logic signed [DW-1:0] X_HI = {1'b0, {(DW - 1){1'b1}}};
	localparam logic signed [DW-1:0] X_LO = {1'b1, {(DW - 1){1'b0}}};

	// a held result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped while stalled");

	// a held result does not change
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(x_out) && $stable(y_out) &&
		$stable(length_out) && $stable(angle_out) && $stable(saturated))
		else $error("result changed while stalled");

	// requests are held back only by a held result
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("in_stall without a held result");

	// a clipped result sits on a rail
	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> (x_out == X_HI || x_out == X_LO ||
		y_out == X_HI || y_out == X_LO))
		else $error("saturated set but no coordinate at a limit");

endmodule

bind vector_polar_convert_rotate_top vpcr_chk u_vpcr_chk (.*);
